[hw/rtl/ptc_pkg.sv]
`default_nettype none
package ptc_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned RAW_W    = 20;
  localparam int unsigned FRONT_LAT = 11;
  localparam int unsigned DIV_LAT  = DATA_W;
  localparam int unsigned BACK_LAT = 5;
  // interval from the edge that accepts start to the edge that samples done high
  localparam int unsigned LATENCY  = FRONT_LAT + DIV_LAT + BACK_LAT;

  localparam logic [DATA_W-1:0] T_OFFSET  = 32'd64000;
  localparam logic [DATA_W-1:0] P_FULL    = 32'd1048576;
  localparam logic [DATA_W-1:0] P_SCALE   = 32'd3125;
  localparam logic [DATA_W-1:0] P1_BIAS   = 32'd32768;
  localparam logic [DATA_W-1:0] T_ROUND   = 32'd128;
  localparam logic [DATA_W-1:0] T_MUL     = 32'd5;

  typedef enum logic [2:0] {
    REG_T1_T2 = 3'd0,
    REG_T3_P1 = 3'd1,
    REG_P2_P3 = 3'd2,
    REG_P4_P5 = 3'd3,
    REG_P6_P7 = 3'd4,
    REG_P8_P9 = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_temperature;
    logic [RAW_W-1:0] raw_pressure;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] temperature_centi;
    logic [DATA_W-1:0]        pressure_pa;
    logic                     pressure_invalid;
  } result_t;

  // coefficients widened to 32 bits as the arithmetic uses them
  typedef struct packed {
    logic [DATA_W-1:0] t1;
    logic [DATA_W-1:0] t2;
    logic [DATA_W-1:0] t3;
    logic [DATA_W-1:0] p1;
    logic [DATA_W-1:0] p2;
    logic [DATA_W-1:0] p3;
    logic [DATA_W-1:0] p4;
    logic [DATA_W-1:0] p5;
    logic [DATA_W-1:0] p6;
    logic [DATA_W-1:0] p7;
    logic [DATA_W-1:0] p8;
    logic [DATA_W-1:0] p9;
  } calib_t;

  typedef struct packed {
    logic [DATA_W-1:0] temp;
    logic              invalid;
    logic              dbl;
  } tag_t;

  typedef struct packed {
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    tag_t              tag;
  } div_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] quotient;
    tag_t              tag;
  } div_rsp_t;

  function automatic logic [DATA_W-1:0] sra(logic [DATA_W-1:0] x, int unsigned n);
    return DATA_W'($signed(x) >>> n);
  endfunction

  function automatic logic [DATA_W-1:0] sx16(logic [15:0] x);
    return {{(DATA_W-16){x[15]}}, x};
  endfunction

  function automatic logic [DATA_W-1:0] zx16(logic [15:0] x);
    return {{(DATA_W-16){1'b0}}, x};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/pressure_temperature_compensation.sv]
// Pressure and temperature compensation, 32-bit fixed point.
// Request channel: drive request with a raw temperature/pressure pair and
// raise start; the pair is taken at any edge where start is high and busy
// is low. busy is high only while rst is held, so one request can enter
// every cycle.
// Result channel: done pulses for one cycle with result valid alongside.
// The path from the accepting edge to the edge that samples done has
// 11 stages of temperature and pressure terms, 32 stages of the
// restoring divider (one quotient bit per stage), and 5 stages of
// pressure correction. Throughput is one result per cycle.
// The receiver cannot stall; results are never held back.
// Configuration: cfg_valid/cfg_ready with cfg_index 0..5 selecting a
// calibration register; other indexes are dropped. cfg_ready is always
// high. Write only while no request is in flight.
// Reset clears all calibration registers to zero and empties the pipeline.
`default_nettype none
module pressure_temperature_compensation import ptc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        request,
  output logic             done,
  output result_t          result,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [DATA_W-1:0] calib_t1_t2, calib_t3_p1, calib_p2_p3;
  logic [DATA_W-1:0] calib_p4_p5, calib_p6_p7, calib_p8_p9;
  calib_t            calib;
  logic              front_valid, div_valid;
  div_req_t          front_data;
  div_rsp_t          div_data;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_t1_t2 <= '0;
      calib_t3_p1 <= '0;
      calib_p2_p3 <= '0;
      calib_p4_p5 <= '0;
      calib_p6_p7 <= '0;
      calib_p8_p9 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_T1_T2: calib_t1_t2 <= cfg_data;
        REG_T3_P1: calib_t3_p1 <= cfg_data;
        REG_P2_P3: calib_p2_p3 <= cfg_data;
        REG_P4_P5: calib_p4_p5 <= cfg_data;
        REG_P6_P7: calib_p6_p7 <= cfg_data;
        REG_P8_P9: calib_p8_p9 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign calib.t1 = zx16(calib_t1_t2[15:0]);
  assign calib.t2 = sx16(calib_t1_t2[31:16]);
  assign calib.t3 = sx16(calib_t3_p1[15:0]);
  assign calib.p1 = zx16(calib_t3_p1[31:16]);
  assign calib.p2 = sx16(calib_p2_p3[15:0]);
  assign calib.p3 = sx16(calib_p2_p3[31:16]);
  assign calib.p4 = sx16(calib_p4_p5[15:0]);
  assign calib.p5 = sx16(calib_p4_p5[31:16]);
  assign calib.p6 = sx16(calib_p6_p7[15:0]);
  assign calib.p7 = sx16(calib_p6_p7[31:16]);
  assign calib.p8 = sx16(calib_p8_p9[15:0]);
  assign calib.p9 = sx16(calib_p8_p9[31:16]);

  ptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .in_data   (request),
    .calib     (calib),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  ptc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  ptc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_data   (div_data),
    .calib     (calib),
    .out_valid (done),
    .out_data  (result)
  );

endmodule
`default_nettype wire

[hw/rtl/ptc_front.sv]
`default_nettype none
module ptc_front import ptc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire req_t     in_data,
  input  wire calib_t   calib,
  output logic          out_valid,
  output div_req_t      out_data
);

  logic [FRONT_LAT-1:0] vld;

  logic [DATA_W-1:0] adc_t, adc_p;
  logic [DATA_W-1:0] s1_ta, s1_d, s1_p;
  logic [DATA_W-1:0] s2_ap, s2_dd, s2_p;
  logic [DATA_W-1:0] s3_a, s3_b, s3_p;
  logic [DATA_W-1:0] s4_tf, s4_p;
  logic [DATA_W-1:0] s5_t5, s5_v1, s5_q, s5_p;
  logic [DATA_W-1:0] v1_comb;
  logic [DATA_W-1:0] s6_temp, s6_qq, s6_v1p5, s6_p2v1, s6_p;
  logic [DATA_W-1:0] s7_temp, s7_v2a, s7_x13, s7_v1p5, s7_p2v1, s7_p;
  logic [DATA_W-1:0] s8_temp, s8_v2, s8_v1b, s8_p;
  logic [DATA_W-1:0] s9_temp, s9_v2, s9_v1c, s9_p;
  logic [DATA_W-1:0] s10_temp, s10_v1, s10_pn;
  logic [DATA_W-1:0] pm;

  assign adc_t   = {{(DATA_W-RAW_W){1'b0}}, in_data.raw_temperature};
  assign adc_p   = {{(DATA_W-RAW_W){1'b0}}, in_data.raw_pressure};
  assign v1_comb = sra(s4_tf, 1) - T_OFFSET;
  assign pm      = DATA_W'(s10_pn * P_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    s1_ta <= (adc_t >> 3) - (calib.t1 << 1);
    s1_d  <= (adc_t >> 4) - calib.t1;
    s1_p  <= adc_p;

    s2_ap <= DATA_W'(s1_ta * calib.t2);
    s2_dd <= DATA_W'(s1_d * s1_d);
    s2_p  <= s1_p;

    s3_a  <= sra(s2_ap, 11);
    s3_b  <= DATA_W'(sra(s2_dd, 12) * calib.t3);
    s3_p  <= s2_p;

    s4_tf <= s3_a + sra(s3_b, 14);
    s4_p  <= s3_p;

    s5_t5 <= DATA_W'(s4_tf * T_MUL);
    s5_v1 <= v1_comb;
    s5_q  <= sra(v1_comb, 2);
    s5_p  <= s4_p;

    s6_temp <= sra(s5_t5 + T_ROUND, 8);
    s6_qq   <= DATA_W'(s5_q * s5_q);
    s6_v1p5 <= DATA_W'(s5_v1 * calib.p5);
    s6_p2v1 <= DATA_W'(calib.p2 * s5_v1);
    s6_p    <= s5_p;

    s7_temp <= s6_temp;
    s7_v2a  <= DATA_W'(sra(s6_qq, 11) * calib.p6);
    s7_x13  <= DATA_W'(calib.p3 * sra(s6_qq, 13));
    s7_v1p5 <= s6_v1p5;
    s7_p2v1 <= s6_p2v1;
    s7_p    <= s6_p;

    s8_temp <= s7_temp;
    s8_v2   <= sra(s7_v2a + (s7_v1p5 << 1), 2) + (calib.p4 << 16);
    s8_v1b  <= sra(sra(s7_x13, 3) + sra(s7_p2v1, 1), 18);
    s8_p    <= s7_p;

    s9_temp <= s8_temp;
    s9_v2   <= s8_v2;
    s9_v1c  <= DATA_W'((P1_BIAS + s8_v1b) * calib.p1);
    s9_p    <= s8_p;

    s10_temp <= s9_temp;
    s10_v1   <= sra(s9_v1c, 15);
    s10_pn   <= (P_FULL - s9_p) - sra(s9_v2, 12);

    // large products are divided first and doubled afterwards
    out_data.dividend    <= pm[DATA_W-1] ? pm : (pm << 1);
    out_data.divisor     <= s10_v1;
    out_data.tag.temp    <= s10_temp;
    out_data.tag.invalid <= (s10_v1 == '0);
    out_data.tag.dbl     <= pm[DATA_W-1];
  end

  assign out_valid = vld[FRONT_LAT-1];

endmodule
`default_nettype wire

[hw/rtl/ptc_div.sv]
`default_nettype none
module ptc_div import ptc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire div_req_t in_data,
  output logic          out_valid,
  output div_rsp_t      out_data
);

  // one quotient bit per stage, restoring
  logic [DATA_W-1:0] rem [0:DIV_LAT];
  logic [DATA_W-1:0] dvd [0:DIV_LAT];
  logic [DATA_W-1:0] dvs [0:DIV_LAT];
  tag_t              tag [0:DIV_LAT];
  logic [DIV_LAT:0]  vld;

  assign rem[0] = '0;
  assign dvd[0] = in_data.dividend;
  assign dvs[0] = in_data.divisor;
  assign tag[0] = in_data.tag;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [DATA_W:0] shifted, diff;
    logic            ge;

    always_comb begin
      shifted = {rem[k], dvd[k][DATA_W-1]};
      diff    = shifted - {1'b0, dvs[k]};
      ge      = !diff[DATA_W];
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      dvd[k+1] <= {dvd[k][DATA_W-2:0], ge};
      dvs[k+1] <= dvs[k];
      tag[k+1] <= tag[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign out_valid         = vld[DIV_LAT];
  assign out_data.quotient = dvd[DIV_LAT];
  assign out_data.tag      = tag[DIV_LAT];

endmodule
`default_nettype wire

[hw/rtl/ptc_back.sv]
`default_nettype none
module ptc_back import ptc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire div_rsp_t in_data,
  input  wire calib_t   calib,
  output logic          out_valid,
  output result_t       out_data
);

  logic [BACK_LAT-2:0] vld;
  tag_t              b1_tag, b2_tag, b3_tag, b4_tag;
  logic [DATA_W-1:0] b1_p, b2_p, b3_p, b4_p;
  logic [DATA_W-1:0] b2_r, b2_pp8, b3_t, b3_pp8, b4_sum;
  logic [DATA_W-1:0] p_final;

  assign p_final = b4_p + sra(b4_sum, 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[BACK_LAT-3:0], in_valid};
      out_valid <= vld[BACK_LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    b1_tag <= in_data.tag;
    b1_p   <= in_data.tag.dbl ? (in_data.quotient << 1) : in_data.quotient;

    b2_tag <= b1_tag;
    b2_p   <= b1_p;
    b2_r   <= DATA_W'((b1_p >> 3) * (b1_p >> 3));
    b2_pp8 <= DATA_W'((b1_p >> 2) * calib.p8);

    b3_tag <= b2_tag;
    b3_p   <= b2_p;
    b3_t   <= DATA_W'(calib.p9 * (b2_r >> 13));
    b3_pp8 <= b2_pp8;

    b4_tag <= b3_tag;
    b4_p   <= b3_p;
    b4_sum <= sra(b3_t, 12) + sra(b3_pp8, 13) + calib.p7;

    out_data.temperature_centi <= b4_tag.temp;
    out_data.pressure_pa       <= b4_tag.invalid ? '0 : p_final;
    out_data.pressure_invalid  <= b4_tag.invalid;
  end

endmodule
`default_nettype wire

[hw/rtl/ptc_checker.sv]
`default_nettype none
module ptc_checker import ptc_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request produced no result at the expected latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.pressure_invalid) |-> (result.pressure_pa == '0))
    else $error("invalid pressure not forced to zero");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result issued right after reset");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import ptc_pkg::*;

  localparam logic [2:0] IDX_SPARE_A = 3'd6;
  localparam logic [2:0] IDX_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 125;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  req_t        request;
  logic        done;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  pressure_temperature_compensation DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [31:0] calib [0:5];
  logic [31:0] cal_sets [0:4][0:5];
  result_t     pending_results [$];
  int          errors = 0;
  int          cycles = 0;

  typedef struct {
    int      cal_sel;
    req_t    req;
    bit      has_exp;
    result_t exp;
  } row_t;

  row_t rows [$];

  function automatic logic [31:0] asr(logic [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic logic [31:0] s16(logic [15:0] x);
    return {{16{x[15]}}, x};
  endfunction

  function automatic result_t compensate(req_t r);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] adc_t, adc_p, a, b, d, tf, v1, v2, q, p;
    result_t res;
    t1 = {16'd0, calib[REG_T1_T2][15:0]};
    t2 = s16(calib[REG_T1_T2][31:16]);
    t3 = s16(calib[REG_T3_P1][15:0]);
    p1 = {16'd0, calib[REG_T3_P1][31:16]};
    p2 = s16(calib[REG_P2_P3][15:0]);
    p3 = s16(calib[REG_P2_P3][31:16]);
    p4 = s16(calib[REG_P4_P5][15:0]);
    p5 = s16(calib[REG_P4_P5][31:16]);
    p6 = s16(calib[REG_P6_P7][15:0]);
    p7 = s16(calib[REG_P6_P7][31:16]);
    p8 = s16(calib[REG_P8_P9][15:0]);
    p9 = s16(calib[REG_P8_P9][31:16]);
    adc_t = {12'd0, r.raw_temperature};
    adc_p = {12'd0, r.raw_pressure};
    a = asr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    b = asr(asr(d * d, 12) * t3, 14);
    tf = a + b;
    res.temperature_centi = asr(tf * 32'd5 + 32'd128, 8);
    v1 = asr(tf, 1) - 32'd64000;
    q = asr(v1, 2);
    v2 = asr(q * q, 11) * p6;
    v2 = v2 + ((v1 * p5) << 1);
    v2 = asr(v2, 2) + (p4 << 16);
    v1 = asr(asr(p3 * asr(q * q, 13), 3) + asr(p2 * v1, 1), 18);
    v1 = asr((32'd32768 + v1) * p1, 15);
    res.pressure_invalid = (v1 == 32'd0);
    if (v1 == 32'd0) begin
      p = 32'd0;
    end else begin
      p = ((32'd1048576 - adc_p) - asr(v2, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / v1;
      else p = (p / v1) * 32'd2;
      v1 = asr(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      v2 = asr((p >> 2) * p8, 13);
      p = p + asr(v1 + v2 + p7, 4);
    end
    res.pressure_pa = p;
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", result.pressure_pa, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (result.temperature_centi !== want.temperature_centi)
          report("temperature_centi", result.temperature_centi, want.temperature_centi);
        if (result.pressure_pa !== want.pressure_pa)
          report("pressure_pa", result.pressure_pa, want.pressure_pa);
        if (result.pressure_invalid !== want.pressure_invalid)
          report("pressure_invalid", {31'd0, result.pressure_invalid},
                 {31'd0, want.pressure_invalid});
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= REG_P8_P9) calib[idx] = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_set(int sel);
    for (int i = 0; i < 6; i++) write_reg(cfg_idx_t'(i), cal_sets[sel][i]);
  endtask

  // hold off until the pipeline is empty
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send(req_t r, bit has_exp, result_t exp);
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    pending_results.push_back(has_exp ? exp : compensate(r));
  endtask

  function automatic logic [15:0] jitter(logic [15:0] base);
    return base + 16'($urandom_range(0, 511)) - 16'd256;
  endfunction

  task automatic load_random(bit wild);
    logic [31:0] v;
    for (int i = 0; i < 6; i++) begin
      if (wild) v = $urandom;
      else v = {jitter(cal_sets[1][i][31:16]), jitter(cal_sets[1][i][15:0])};
      if (wild && i == REG_T3_P1 && $urandom_range(0, 7) == 0) v[31:16] = 16'd0;
      write_reg(cfg_idx_t'(i), v);
    end
  endtask

  function automatic req_t random_req();
    req_t r;
    if ($urandom_range(0, 99) < 70) begin
      r.raw_temperature = 20'($urandom_range(400000, 640000));
      r.raw_pressure    = 20'($urandom_range(200000, 500000));
    end else begin
      r.raw_temperature = 20'($urandom);
      r.raw_pressure    = 20'($urandom);
    end
    return r;
  endfunction

  task automatic add_row(int sel, logic [19:0] rt, logic [19:0] rp, bit has_exp,
                         logic [31:0] temp, logic [31:0] pa, logic inv);
    row_t row;
    row.cal_sel = sel;
    row.req.raw_temperature = rt;
    row.req.raw_pressure = rp;
    row.has_exp = has_exp;
    row.exp.temperature_centi = temp;
    row.exp.pressure_pa = pa;
    row.exp.pressure_invalid = inv;
    rows.push_back(row);
  endtask

  initial begin
    int idle_pct [0:3];
    result_t none;
    none = '0;
    idle_pct = '{0, 64, 0, 21};
    cal_sets[0] = '{6{32'd0}};
    cal_sets[1] = '{32'h6743_6B70, 32'h8E7D_FC18, 32'h0BD0_D643,
                    32'h008C_0B27, 32'h3C8C_FFF9, 32'h1770_C6F8};
    cal_sets[2] = '{32'h7FFF_FFFF, 32'hFFFF_7FFF, 32'h7FFF_7FFF,
                    32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF};
    cal_sets[3] = '{32'h8000_0000, 32'hFFFF_8000, 32'h8000_8000,
                    32'h8000_8000, 32'h8000_8000, 32'h8000_8000};
    cal_sets[4] = '{32'h6743_6B70, 32'h0000_FC18, 32'h0BD0_D643,
                    32'h008C_0B27, 32'h3C8C_FFF9, 32'h1770_C6F8};
    for (int i = 0; i < 6; i++) calib[i] = 32'd0;

    // cleared calibration: divisor is zero, temperature rounds to zero
    add_row(-1, 20'd0,       20'd0,       1, 32'd0, 32'd0, 1'b1);
    add_row(-1, 20'hFFFFF,   20'hFFFFF,   1, 32'd0, 32'd0, 1'b1);
    add_row(-1, 20'h80000,   20'h7FFFF,   1, 32'd0, 32'd0, 1'b1);
    add_row(1,  20'd519888,  20'd415148,  0, 0, 0, 0);
    add_row(-1, 20'd0,       20'd0,       0, 0, 0, 0);
    add_row(-1, 20'hFFFFF,   20'hFFFFF,   0, 0, 0, 0);
    add_row(-1, 20'd0,       20'hFFFFF,   0, 0, 0, 0);
    add_row(-1, 20'hFFFFF,   20'd0,       0, 0, 0, 0);
    add_row(-1, 20'hAAAAA,   20'h55555,   0, 0, 0, 0);
    add_row(2,  20'd0,       20'd0,       0, 0, 0, 0);
    add_row(-1, 20'hFFFFF,   20'hFFFFF,   0, 0, 0, 0);
    add_row(-1, 20'd519888,  20'd415148,  0, 0, 0, 0);
    add_row(3,  20'd0,       20'hFFFFF,   0, 0, 0, 0);
    add_row(-1, 20'hFFFFF,   20'd0,       0, 0, 0, 0);
    add_row(-1, 20'h55555,   20'hAAAAA,   0, 0, 0, 0);
    // zero pressure coefficient one forces the invalid path
    add_row(4,  20'd519888,  20'd415148,  0, 0, 0, 0);
    add_row(-1, 20'hFFFFF,   20'd0,       0, 0, 0, 0);

    rst = 1'b1;
    start = 1'b0;
    request = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].cal_sel >= 0) begin
        drain();
        load_set(rows[i].cal_sel);
        // spare indexes must be dropped
        if (rows[i].cal_sel == 1) begin
          write_reg(IDX_SPARE_A, 32'hDEAD_BEEF);
          write_reg(IDX_SPARE_B, 32'h0000_0000);
        end
      end
      send(rows[i].req, rows[i].has_exp, rows[i].exp);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      load_random(ph[0]);
      for (int n = 0; n < PHASE_ITEMS / 2; n++) begin
        send(random_req(), 0, none);
        if ($urandom_range(0, 99) < idle_pct[ph % 4]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
